### hdl/ces_pkg.sv
// Shared constants and types for the countdown event scheduler.
// No dependencies; imported by every module of the block.
package ces_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int RESULT_SLOTS = 16;

   localparam int DELAY_W = 16;
   localparam int ID_W    = 8;
   localparam int TICK_W  = 16;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int REP_W = $clog2(RESULT_SLOTS + 1);

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_SCHED = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [DELAY_W-1:0] delay;
      logic [ID_W-1:0]    id;
   } ces_entry_type;

   // what the shared age unit reports for the entry under the read pointer
   typedef struct packed {
      logic          due;
      ces_entry_type aged;
   } ces_probe_type;

endpackage

### hdl/countdown_event_scheduler.sv
// Countdown event scheduler: tick counter, ordered event table, walk sequencer.
// Depends on ces_pkg and ces_table.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   request  | start / busy              | req_func, req_delay_ticks, req_event_id
//   response | rsp_strobe (one cycle)    | rsp_status, rsp_fired_valid, rsp_fired_id,
//            |                           | rsp_tick_count, rsp_last
//
// A schedule item's response appears the next cycle and busy stays low. A tick
// item keeps busy high while the sequencer walks the entries held (up to
// TABLE_DEPTH), visiting one table entry per cycle through the single table read
// port and age unit, then a closing step ends the walk.
// A fired event is held until the next due entry is found or the walk closes;
// it leaves the cycle after that, and the held one at the close carries last.
// Reset is synchronous; it clears counter, fill count and sequencer; table
// contents are not cleared. Responses cannot be stalled.
module countdown_event_scheduler
   import ces_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [DELAY_W-1:0] req_delay_ticks,
   input  logic [ID_W-1:0]    req_event_id,
   output logic               rsp_strobe,
   output logic               rsp_status,
   output logic               rsp_fired_valid,
   output logic [ID_W-1:0]    rsp_fired_id,
   output logic [TICK_W-1:0]  rsp_tick_count,
   output logic               rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [REP_W-1:0]  rep_ff, rep_in;
   logic              strobe_ff, strobe_in;
   logic              status_ff, status_in;
   logic              fv_ff, fv_in;
   logic [ID_W-1:0]   fid_ff, fid_in;
   logic              last_ff, last_in;

   logic              accept;
   logic              tbl_wr_en;
   logic [IDX_W-1:0]  tbl_wr_idx;
   ces_entry_type     tbl_wr_entry;
   ces_probe_type     probe;

   ces_table u_table (
      .clock    (clock),
      .wr_en    (tbl_wr_en),
      .wr_idx   (tbl_wr_idx),
      .wr_entry (tbl_wr_entry),
      .rd_idx   (rd_ff[IDX_W-1:0]),
      .probe    (probe)
   );

   assign busy   = (state_ff == ST_WALK);
   assign accept = start && !busy;

   always_comb begin
      state_in      = state_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      tick_in       = tick_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rep_in        = rep_ff;
      strobe_in     = 1'b0;
      status_in     = STATUS_OK;
      fv_in         = 1'b0;
      fid_in        = '0;
      last_in       = 1'b0;
      tbl_wr_en     = 1'b0;
      tbl_wr_idx    = count_ff[IDX_W-1:0];
      tbl_wr_entry.delay = req_delay_ticks;
      tbl_wr_entry.id    = req_event_id;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_SCHED) begin
                  strobe_in = 1'b1;
                  last_in   = 1'b1;
                  if (req_event_id != '0) begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        tbl_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
               end else begin
                  tick_in       = tick_ff + TICK_W'(1);
                  rd_in         = '0;
                  wr_in         = '0;
                  pend_valid_in = 1'b0;
                  rep_in        = '0;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (rd_ff == count_ff) begin
               // close: the held event (if any) is the final response
               count_in  = wr_ff;
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               last_in   = 1'b1;
               fv_in     = pend_valid_ff;
               fid_in    = pend_valid_ff ? pend_id_ff : '0;
            end else begin
               rd_in = rd_ff + CNT_W'(1);
               if (probe.due) begin
                  if (rep_ff < REP_W'(RESULT_SLOTS)) begin
                     rep_in        = rep_ff + REP_W'(1);
                     pend_valid_in = 1'b1;
                     pend_id_in    = probe.aged.id;
                     if (pend_valid_ff) begin
                        strobe_in = 1'b1;
                        fv_in     = 1'b1;
                        fid_in    = pend_id_ff;
                     end
                  end
               end else begin
                  tbl_wr_en    = 1'b1;
                  tbl_wr_idx   = wr_ff[IDX_W-1:0];
                  tbl_wr_entry = probe.aged;
                  wr_in        = wr_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_ff         <= '0;
         wr_ff         <= '0;
         count_ff      <= '0;
         tick_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rep_ff        <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
         pend_valid_ff <= pend_valid_in;
         rep_ff        <= rep_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff <= pend_id_in;
      status_ff  <= status_in;
      fv_ff      <= fv_in;
      fid_ff     <= fid_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_fired_valid = fv_ff;
   assign rsp_fired_id    = fid_ff;
   assign rsp_tick_count  = tick_ff;
   assign rsp_last        = last_ff;

endmodule

### hdl/ces_table.sv
// Event table storage plus the shared age unit (zero test and decrement).
// Depends on ces_pkg.
module ces_table
   import ces_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_idx,
   input  ces_entry_type        wr_entry,
   input  logic [IDX_W-1:0]     rd_idx,
   output ces_probe_type        probe
);

   ces_entry_type entry_ff [TABLE_DEPTH];
   ces_entry_type cur;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

   assign cur = entry_ff[rd_idx];

   always_comb begin
      probe.due        = (cur.delay == '0);
      probe.aged.delay = cur.delay - DELAY_W'(1);
      probe.aged.id    = cur.id;
   end

endmodule

### hdl/ces_checker.sv
// Port-level checks for the countdown event scheduler, bound to the top level.
// Depends on ces_pkg and countdown_event_scheduler.
module ces_checker
   import ces_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_func,
   input logic              rsp_strobe,
   input logic              rsp_status,
   input logic              rsp_fired_valid,
   input logic [ID_W-1:0]   rsp_fired_id,
   input logic              rsp_last
);

   // a response with no fired event closes its item
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_fired_valid |-> rsp_last)
      else $error("non-event response without last");

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_fired_valid |-> rsp_fired_id == '0)
      else $error("fired_id set without fired event");

   a_fire_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_fired_valid |-> rsp_status == STATUS_OK)
      else $error("fired event with full status");

   a_sched_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_SCHED |=> rsp_strobe && rsp_last && !busy)
      else $error("schedule item did not answer next cycle");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_TICK |=> busy)
      else $error("tick item did not start a walk");

endmodule

bind countdown_event_scheduler ces_checker u_ces_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_fired_valid (rsp_fired_valid),
   .rsp_fired_id    (rsp_fired_id),
   .rsp_last        (rsp_last)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for countdown_event_scheduler: directed and random schedule/tick
// items checked against an in-bench model of the event table and tick counter.
// Depends on ces_pkg and the countdown_event_scheduler RTL.
module tb_top;
   import ces_pkg::*;

   localparam int RANDOM_ITEMS  = 445;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic               func;
      logic [DELAY_W-1:0] delay;
      logic [ID_W-1:0]    id;
      int                 gap;
      bit                 hold;   // wait for every outstanding result before offering
   } sched_item_type;

   typedef struct {
      logic              status;
      logic              fired_valid;
      logic [ID_W-1:0]   fired_id;
      logic [TICK_W-1:0] tick_count;
      logic              last;
   } event_report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               req_func = FUNC_TICK;
   logic [DELAY_W-1:0] req_delay_ticks = '0;
   logic [ID_W-1:0]    req_event_id = '0;
   logic               busy;
   logic               rsp_strobe;
   logic               rsp_status;
   logic               rsp_fired_valid;
   logic [ID_W-1:0]    rsp_fired_id;
   logic [TICK_W-1:0]  rsp_tick_count;
   logic               rsp_last;

   countdown_event_scheduler dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_delay_ticks (req_delay_ticks),
      .req_event_id    (req_event_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_fired_valid (rsp_fired_valid),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_tick_count  (rsp_tick_count),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // event table model
   logic [TICK_W-1:0]  tick_now = '0;
   logic [DELAY_W-1:0] slot_delay [TABLE_DEPTH];
   logic [ID_W-1:0]    slot_id [TABLE_DEPTH];
   int                 slots_used = 0;

   sched_item_type   pend_q[$];
   event_report_type report_q[$];
   int               results_due = 0;
   int               results_seen = 0;
   int               errors = 0;
   int               n_sched = 0, n_tick = 0, n_fired = 0, n_full = 0, n_ignored = 0;
   int               max_burst = 0;

   function automatic void advance_scheduler(input sched_item_type it);
      event_report_type rep, prev;
      bit               have_prev;
      int               keep, fired;
      rep.status      = STATUS_OK;
      rep.fired_valid = 1'b0;
      rep.fired_id    = '0;
      rep.last        = 1'b1;
      if (it.func == FUNC_SCHED) begin
         n_sched++;
         rep.tick_count = tick_now;
         if (it.id == '0) begin
            n_ignored++;
         end else if (slots_used >= TABLE_DEPTH) begin
            rep.status = STATUS_FULL;
            n_full++;
         end else begin
            slot_delay[IDX_W'(slots_used)] = it.delay;
            slot_id[IDX_W'(slots_used)]    = it.id;
            slots_used++;
         end
         report_q.push_back(rep);
         results_due++;
      end else begin
         n_tick++;
         tick_now       = tick_now + TICK_W'(1);
         rep.tick_count = tick_now;
         keep           = 0;
         fired          = 0;
         have_prev      = 1'b0;
         for (int k = 0; k < slots_used; k++) begin
            if (slot_delay[IDX_W'(k)] == '0) begin
               if (fired < RESULT_SLOTS) begin
                  if (have_prev)
                     report_q.push_back(prev);
                  prev             = rep;
                  prev.fired_valid = 1'b1;
                  prev.fired_id    = slot_id[IDX_W'(k)];
                  prev.last        = 1'b0;
                  have_prev        = 1'b1;
                  fired++;
               end
            end else begin
               slot_delay[IDX_W'(keep)] = slot_delay[IDX_W'(k)] - DELAY_W'(1);
               slot_id[IDX_W'(keep)]    = slot_id[IDX_W'(k)];
               keep++;
            end
         end
         slots_used = keep;
         if (have_prev) begin
            prev.last = 1'b1;
            report_q.push_back(prev);
            results_due += fired;
         end else begin
            report_q.push_back(rep);
            results_due++;
         end
         n_fired += fired;
         if (fired > max_burst)
            max_burst = fired;
      end
   endfunction

   function automatic sched_item_type random_item(input int idx);
      sched_item_type it;
      int             pick;
      it.func = ($urandom_range(99) < 55) ? FUNC_SCHED : FUNC_TICK;
      pick = $urandom_range(99);
      if (pick < 85)
         it.delay = DELAY_W'($urandom_range(7));
      else if (pick < 97)
         it.delay = DELAY_W'($urandom_range(60, 8));
      else
         it.delay = DELAY_W'($urandom());
      it.id = ($urandom_range(99) < 8) ? '0 : ID_W'($urandom_range(255, 1));
      pick = $urandom_range(99);
      // every third block of 50 items runs back to back
      if ((idx / 50) % 3 == 2 || pick < 65)
         it.gap = 0;
      else if (pick < 94)
         it.gap = $urandom_range(3, 1);
      else
         it.gap = $urandom_range(40, 10);
      it.hold = (idx == 200) || ($urandom_range(99) == 0);
      return it;
   endfunction

   task automatic queue_item(input logic func, input logic [DELAY_W-1:0] delay,
                             input logic [ID_W-1:0] id, input int gap, input bit hold);
      sched_item_type it;
      it.func  = func;
      it.delay = delay;
      it.id    = id;
      it.gap   = gap;
      it.hold  = hold;
      pend_q.push_back(it);
   endtask

   // driver
   sched_item_type cur;
   bit             loaded = 1'b0;
   int             gap_left = 0;

   always @(posedge clock) begin
      bit go;
      go = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            advance_scheduler(cur);
            loaded = 1'b0;
         end
         if (!loaded && pend_q.size() != 0) begin
            cur      = pend_q.pop_front();
            loaded   = 1'b1;
            gap_left = cur.gap;
         end
         if (loaded) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!cur.hold || results_due == results_seen) begin
               go       = 1'b1;
               cur.hold = 1'b0;   // keep start up once offered
            end
         end
         start <= go;
         if (go) begin
            req_func        <= cur.func;
            req_delay_ticks <= cur.delay;
            req_event_id    <= cur.id;
         end
      end
   end

   task automatic check_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want_v, got_v);
      end
   endtask

   // monitor
   always @(posedge clock) begin
      event_report_type want;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (report_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got id %0h tick %0h",
                     $realtime, rsp_fired_id, rsp_tick_count);
         end else begin
            want = report_q.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("fired_valid", 32'(want.fired_valid), 32'(rsp_fired_valid));
            check_field("fired_id", 32'(want.fired_id), 32'(rsp_fired_id));
            check_field("tick_count", 32'(want.tick_count), 32'(rsp_tick_count));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // watchdog: cycles with neither an item nor a result accepted
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no progress for %0d cycles", $realtime, IDLE_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // empty tick, ignored id, multi-fire with a survivor in between
      queue_item(FUNC_TICK, '0, '0, 0, 1'b0);
      queue_item(FUNC_SCHED, 16'hFFFF, 8'h00, 0, 1'b0);
      queue_item(FUNC_SCHED, 16'h0000, 8'hFF, 0, 1'b0);
      queue_item(FUNC_SCHED, 16'h0001, 8'h55, 2, 1'b0);
      queue_item(FUNC_SCHED, 16'h0000, 8'hAA, 0, 1'b0);
      queue_item(FUNC_TICK, 16'hFFFF, 8'hFF, 0, 1'b1);
      queue_item(FUNC_TICK, '0, '0, 2, 1'b0);
      // fill the table, then full and ignored-when-full
      for (int k = 0; k < TABLE_DEPTH; k++)
         queue_item(FUNC_SCHED, DELAY_W'(k % 3), ID_W'(k * 13 + 1), 0, 1'b0);
      queue_item(FUNC_SCHED, 16'h0003, 8'h01, 0, 1'b0);
      queue_item(FUNC_SCHED, 16'h0003, 8'h00, 0, 1'b0);
      for (int k = 0; k < RANDOM_ITEMS; k++)
         pend_q.push_back(random_item(k));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pend_q.size() != 0 || loaded || results_due != results_seen)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (report_q.size() != 0) begin
         $display("%0t: %0d results expected, none arrived", $realtime, report_q.size());
         errors += report_q.size();
      end
      $display("covered %0d schedules (%0d full, %0d ignored), %0d ticks, %0d fired",
               n_sched, n_full, n_ignored, n_tick, n_fired);
      $display("largest burst of fired events in one tick: %0d", max_burst);
      if (errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
